// ===== design/yuv_range_row_obstacle_filter_assert.svh =====
// ----------------------------------------------------------------------------
// yuv range row obstacle filter assertion macros
// concurrent check wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef YUV_RANGE_ROW_OBSTACLE_FILTER_ASSERT_SVH
`define YUV_RANGE_ROW_OBSTACLE_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition holds on every clock out of reset
`define YROF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("yrof check failed");
// antecedent implies consequent in the same cycle
`define YROF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yrof check failed");
`else
`define YROF_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define YROF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/yrof_pkg.sv =====
// ----------------------------------------------------------------------------
// yrof_pkg
// shared constants, register codes and the command word of the row filter
// ----------------------------------------------------------------------------
package yrof_pkg;

    // pixel component width
    localparam int PIX_W = 8;
    // held segment buffer
    localparam int PENDING_DEPTH = 16;
    localparam int PEND_IDX_W    = $clog2(PENDING_DEPTH);
    localparam int LEN_W         = $clog2(PENDING_DEPTH + 1);
    // run counters
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] MAX_FREE_RUN    = CNT_W'(4);
    localparam logic [CNT_W-1:0] MAX_BLACK_COUNT = CNT_W'(4);
    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_MIN        = 3'd0,
        REG_LUMA_MAX        = 3'd1,
        REG_BLUE_MIN        = 3'd2,
        REG_BLUE_MAX        = 3'd3,
        REG_RED_MIN         = 3'd4,
        REG_RED_MAX         = 3'd5,
        REG_FREE_RUN_NEEDED = 3'd6,
        REG_BLACK_NEEDED    = 3'd7
    } cfg_reg_t;

    // register reset values
    localparam logic [PIX_W-1:0] LUMA_MIN_RST = 8'd90;
    localparam logic [PIX_W-1:0] LUMA_MAX_RST = 8'd210;
    localparam logic [PIX_W-1:0] BLUE_MIN_RST = 8'd75;
    localparam logic [PIX_W-1:0] BLUE_MAX_RST = 8'd115;
    localparam logic [PIX_W-1:0] RED_MIN_RST  = 8'd69;
    localparam logic [PIX_W-1:0] RED_MAX_RST  = 8'd145;
    localparam logic [CNT_W-1:0] FREE_RUN_RST = 3'd3;
    localparam logic [CNT_W-1:0] BLACK_RST    = 3'd3;

    // one command: flush_len held marks (kept or forced to tail_mark),
    // then an optional tail word; row_end tags the final word
    typedef struct packed {
        logic [PENDING_DEPTH-1:0] marks;
        logic [LEN_W-1:0]         flush_len;
        logic                     flush_keep;
        logic                     tail_valid;
        logic                     tail_mark;
        logic                     row_end;
    } cmd_t;

endpackage

// ===== design/yrof_front.sv =====
// ----------------------------------------------------------------------------
// yrof_front
// range classification, row cleanup state and configuration registers;
// turns each accepted pixel into at most one output command
// ----------------------------------------------------------------------------
module yrof_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    input  logic [yrof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yrof_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel in
    input  logic                              pix_accept,
    input  logic [yrof_pkg::PIX_W-1:0]        luma,
    input  logic [yrof_pkg::PIX_W-1:0]        blue_diff,
    input  logic [yrof_pkg::PIX_W-1:0]        red_diff,
    input  logic                              last_in_row,
    // command out
    output logic                              cmd_push,
    output yrof_pkg::cmd_t                    cmd
);

    // configuration registers
    logic [yrof_pkg::PIX_W-1:0] luma_min_reg, luma_max_reg;
    logic [yrof_pkg::PIX_W-1:0] blue_min_reg, blue_max_reg;
    logic [yrof_pkg::PIX_W-1:0] red_min_reg, red_max_reg;
    logic [yrof_pkg::CNT_W-1:0] free_run_needed_reg, black_needed_reg;

    // row state
    logic                               row_locked_reg, row_locked_next;
    logic [yrof_pkg::CNT_W-1:0]         black_seen_reg, black_seen_next;
    logic [yrof_pkg::CNT_W-1:0]         free_streak_reg, free_streak_next;
    logic                               segment_open_reg, segment_open_next;
    logic [yrof_pkg::LEN_W-1:0]         pending_length_reg, pending_length_next;
    logic [yrof_pkg::PENDING_DEPTH-1:0] pending_marks_reg, pending_marks_next;

    logic is_free;

    // config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_min_reg        <= yrof_pkg::LUMA_MIN_RST;
            luma_max_reg        <= yrof_pkg::LUMA_MAX_RST;
            blue_min_reg        <= yrof_pkg::BLUE_MIN_RST;
            blue_max_reg        <= yrof_pkg::BLUE_MAX_RST;
            red_min_reg         <= yrof_pkg::RED_MIN_RST;
            red_max_reg         <= yrof_pkg::RED_MAX_RST;
            free_run_needed_reg <= yrof_pkg::FREE_RUN_RST;
            black_needed_reg    <= yrof_pkg::BLACK_RST;
        end else if (cfg_valid) begin
            unique case (yrof_pkg::cfg_reg_t'(cfg_index))
                yrof_pkg::REG_LUMA_MIN:        luma_min_reg <= cfg_data;
                yrof_pkg::REG_LUMA_MAX:        luma_max_reg <= cfg_data;
                yrof_pkg::REG_BLUE_MIN:        blue_min_reg <= cfg_data;
                yrof_pkg::REG_BLUE_MAX:        blue_max_reg <= cfg_data;
                yrof_pkg::REG_RED_MIN:         red_min_reg  <= cfg_data;
                yrof_pkg::REG_RED_MAX:         red_max_reg  <= cfg_data;
                yrof_pkg::REG_FREE_RUN_NEEDED:
                    free_run_needed_reg <= cfg_data[yrof_pkg::CNT_W-1:0];
                yrof_pkg::REG_BLACK_NEEDED:
                    black_needed_reg <= cfg_data[yrof_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // inclusive range check on all three components
    assign is_free = (luma >= luma_min_reg) && (luma <= luma_max_reg) &&
                     (blue_diff >= blue_min_reg) && (blue_diff <= blue_max_reg) &&
                     (red_diff >= red_min_reg) && (red_diff <= red_max_reg);

    // row cleanup decision and command build
    always_comb begin
        row_locked_next     = row_locked_reg;
        black_seen_next     = black_seen_reg;
        free_streak_next    = free_streak_reg;
        segment_open_next   = segment_open_reg;
        pending_length_next = pending_length_reg;
        pending_marks_next  = pending_marks_reg;

        cmd.marks      = pending_marks_reg;
        cmd.flush_len  = '0;
        cmd.flush_keep = 1'b0;
        cmd.tail_valid = 1'b0;
        cmd.tail_mark  = 1'b0;
        cmd.row_end    = last_in_row;

        if (row_locked_reg) begin
            // rest of row goes black
            cmd.tail_valid = 1'b1;
            cmd.tail_mark  = 1'b0;
        end else begin
            // run counters
            if (!is_free) begin
                if (!segment_open_reg) begin
                    segment_open_next   = 1'b1;
                    pending_length_next = '0;
                    black_seen_next     = '0;
                end
                if (black_seen_next < yrof_pkg::MAX_BLACK_COUNT) begin
                    black_seen_next = black_seen_next + 1'b1;
                end
                free_streak_next = '0;
            end else if (free_streak_reg < yrof_pkg::MAX_FREE_RUN) begin
                free_streak_next = free_streak_reg + 1'b1;
            end

            priority if (!segment_open_next) begin
                // outside a segment: pass straight through
                cmd.tail_valid = 1'b1;
                cmd.tail_mark  = is_free;
            end else if (is_free && (free_streak_next >= free_run_needed_reg)) begin
                // resolved free: held pixels turn white
                cmd.flush_len       = pending_length_next;
                cmd.tail_valid      = 1'b1;
                cmd.tail_mark       = 1'b1;
                pending_length_next = '0;
                segment_open_next   = 1'b0;
                black_seen_next     = '0;
            end else if (black_seen_next >= black_needed_reg) begin
                // resolved black: held pixels turn black, row locks
                cmd.flush_len       = pending_length_next;
                cmd.tail_valid      = 1'b1;
                cmd.tail_mark       = 1'b0;
                pending_length_next = '0;
                segment_open_next   = 1'b0;
                black_seen_next     = '0;
                row_locked_next     = 1'b1;
            end else begin
                // hold this pixel; a full buffer goes out unchanged
                pending_marks_next[pending_length_next[yrof_pkg::PEND_IDX_W-1:0]] = is_free;
                pending_length_next = pending_length_next + 1'b1;
                cmd.marks = pending_marks_next;
                if (pending_length_next ==
                    yrof_pkg::LEN_W'(yrof_pkg::PENDING_DEPTH)) begin
                    cmd.flush_len       = pending_length_next;
                    cmd.flush_keep      = 1'b1;
                    pending_length_next = '0;
                    segment_open_next   = 1'b0;
                    black_seen_next     = '0;
                end
            end
        end

        // row end: still open segment goes out unchanged, row state clears
        if (last_in_row) begin
            if (segment_open_next) begin
                cmd.flush_len  = pending_length_next;
                cmd.flush_keep = 1'b1;
            end
            row_locked_next     = 1'b0;
            black_seen_next     = '0;
            free_streak_next    = '0;
            segment_open_next   = 1'b0;
            pending_length_next = '0;
        end
    end

    // a held pixel that is not the row end yields nothing
    assign cmd_push = pix_accept && (cmd.tail_valid || (cmd.flush_len != '0));

    // row state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_locked_reg     <= 1'b0;
            black_seen_reg     <= '0;
            free_streak_reg    <= '0;
            segment_open_reg   <= 1'b0;
            pending_length_reg <= '0;
        end else if (pix_accept) begin
            row_locked_reg     <= row_locked_next;
            black_seen_reg     <= black_seen_next;
            free_streak_reg    <= free_streak_next;
            segment_open_reg   <= segment_open_next;
            pending_length_reg <= pending_length_next;
        end
    end

    // held marks, no reset: only entries below the length are read
    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            pending_marks_reg <= pending_marks_next;
        end
    end

endmodule

// ===== design/yrof_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// yrof_cmd_fifo
// short command queue between the classifying front and the output back
// ----------------------------------------------------------------------------
module yrof_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  yrof_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output yrof_pkg::cmd_t  head_cmd,
    output logic            full,
    output logic            empty
);

    yrof_pkg::cmd_t                   entry_reg [yrof_pkg::CMD_DEPTH];
    logic [yrof_pkg::CMD_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [yrof_pkg::CMD_CNT_W-1:0]   count_reg;

    assign full     = (count_reg == yrof_pkg::CMD_CNT_W'(yrof_pkg::CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/yrof_back.sv =====
// ----------------------------------------------------------------------------
// yrof_back
// expands commands into output words, one per cycle while m_tready allows,
// through a held output register
// ----------------------------------------------------------------------------
module yrof_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  yrof_pkg::cmd_t  head_cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            free_space,
    output logic            last_result,
    output logic            row_done
);

    logic [yrof_pkg::LEN_W-1:0] pos_reg;
    logic                       out_valid_reg;
    logic                       free_space_reg, last_result_reg, row_done_reg;

    logic load, take, in_flush, word_mark, word_final;

    assign load = !out_valid_reg || m_tready;
    assign take = load && !cmd_empty;

    // pick the next word of the head command
    assign in_flush  = (pos_reg < head_cmd.flush_len);
    assign word_mark = (in_flush && head_cmd.flush_keep)
                     ? head_cmd.marks[pos_reg[yrof_pkg::PEND_IDX_W-1:0]]
                     : head_cmd.tail_mark;
    assign word_final = in_flush
                      ? ((pos_reg == head_cmd.flush_len - 1'b1) && !head_cmd.tail_valid)
                      : 1'b1;

    assign cmd_pop = take && word_final;

    // walk position and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                pos_reg <= word_final ? '0 : pos_reg + 1'b1;
            end
            if (load) begin
                out_valid_reg <= !cmd_empty;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (take) begin
            free_space_reg  <= word_mark;
            last_result_reg <= word_final;
            row_done_reg    <= word_final && head_cmd.row_end;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign free_space  = free_space_reg;
    assign last_result = last_result_reg;
    assign row_done    = row_done_reg;

endmodule

// ===== design/yuv_range_row_obstacle_filter.sv =====
// path: a pixel passed straight through is written to the command queue, then
//   loaded into the output register; held pixels come out when their segment resolves
// throughput: one pixel per cycle while the 4-deep command queue has room; a
//   flush of up to 16 words drains one word per cycle from the back end while m_tready is high
// reset: aresetn synchronous active low; registers return to defaults, row
//   state clears and the queue and output register empty
// ----------------------------------------------------------------------------
// yuv_range_row_obstacle_filter
// marks yuv pixels free or obstacle by range and cleans up each row
// ----------------------------------------------------------------------------
`include "yuv_range_row_obstacle_filter_assert.svh"

module yuv_range_row_obstacle_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [yrof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yrof_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // luma, blue_diff, red_diff
    input  logic                              s_tlast,   // last_in_row
    // result stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // free_space, zero fill
    output logic [0:0]                        m_tuser,   // last_result
    output logic                              m_tlast    // row_done
);

    logic           pix_accept;
    logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
    yrof_pkg::cmd_t push_cmd, head_cmd;
    logic           free_space, last_result, row_done;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !cmd_full;
    assign pix_accept = s_tvalid && s_tready;

    // classify and resolve
    yrof_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_accept  (pix_accept),
        .luma        (s_tdata[7:0]),
        .blue_diff   (s_tdata[15:8]),
        .red_diff    (s_tdata[23:16]),
        .last_in_row (s_tlast),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    // command queue
    yrof_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .full     (cmd_full),
        .empty    (cmd_empty)
    );

    // word output
    yrof_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .free_space  (free_space),
        .last_result (last_result),
        .row_done    (row_done)
    );

    assign m_tdata = {7'd0, free_space};
    assign m_tuser = last_result;
    assign m_tlast = row_done;

    // checks
    `YROF_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, cmd_push, !cmd_full)
    `YROF_ASSERT_IMPLIES(a_row_end_pushes, aclk, aresetn, pix_accept && s_tlast, cmd_push)
    `YROF_ASSERT_IMPLIES(a_row_done_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the yuv range row obstacle filter: a table of
// directed pixels, then random rows under several register settings, every
// result word checked in order against a cycle-free model of the row cleanup
// ----------------------------------------------------------------------------
module tb;
    import yrof_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic free_space;
        logic last_result;
        logic row_done;
    } mark_word_t;

    typedef struct {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        bit         eol;
        int         typed;   // -1: use the model, else the single mark of the row
    } pixel_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;   // luma, blue_diff, red_diff
    logic                  s_tlast = 1'b0; // last_in_row
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // free_space, zero fill
    logic [0:0]            m_tuser;        // last_result
    logic                  m_tlast;        // row_done

    // register copy and row state of the model
    logic [7:0]       cur_cfg [8];
    bit               row_locked;
    logic [CNT_W-1:0] black_seen;
    logic [CNT_W-1:0] free_streak;
    bit               seg_open;
    bit               held_marks [PENDING_DEPTH];
    int               held_len;
    bit               step_marks [$];

    mark_word_t due_marks [$];

    int  errors;
    int  pixel_count;
    int  row_count;
    int  word_count;
    int  setting_count;
    bit  calm;

    yuv_range_row_obstacle_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void report(string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    // ------------------------------------------------------------------------
    // model of the filter
    // ------------------------------------------------------------------------
    function automatic bit in_ranges(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        return y >= cur_cfg[REG_LUMA_MIN] && y <= cur_cfg[REG_LUMA_MAX] &&
               u >= cur_cfg[REG_BLUE_MIN] && u <= cur_cfg[REG_BLUE_MAX] &&
               v >= cur_cfg[REG_RED_MIN]  && v <= cur_cfg[REG_RED_MAX];
    endfunction

    // emit the held segment, kept or forced to one mark, and close it
    function automatic void release_segment(bit keep, bit forced);
        for (int i = 0; i < held_len; i++)
            step_marks.push_back(keep ? held_marks[i] : forced);
        held_len   = 0;
        seg_open   = 1'b0;
        black_seen = '0;
    endfunction

    function automatic void clear_row();
        row_locked  = 1'b0;
        black_seen  = '0;
        free_streak = '0;
        seg_open    = 1'b0;
        held_len    = 0;
    endfunction

    // marks released by one pixel, in output order
    function automatic void filter_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                         bit eol);
        bit is_free;
        is_free = in_ranges(y, u, v);
        step_marks.delete();
        if (row_locked) begin
            step_marks.push_back(1'b0);
        end else begin
            if (!is_free) begin
                if (!seg_open) begin
                    seg_open   = 1'b1;
                    held_len   = 0;
                    black_seen = '0;
                end
                if (black_seen < MAX_BLACK_COUNT) black_seen++;
                free_streak = '0;
            end else if (free_streak < MAX_FREE_RUN) begin
                free_streak++;
            end

            if (!seg_open) begin
                step_marks.push_back(is_free);
            end else if (is_free && free_streak >= cur_cfg[REG_FREE_RUN_NEEDED][2:0]) begin
                release_segment(1'b0, 1'b1);
                step_marks.push_back(1'b1);
            end else if (black_seen >= cur_cfg[REG_BLACK_NEEDED][2:0]) begin
                release_segment(1'b0, 1'b0);
                step_marks.push_back(1'b0);
                row_locked = 1'b1;
            end else begin
                if (held_len < PENDING_DEPTH) begin
                    held_marks[held_len] = is_free;
                    held_len++;
                end
                // buffer full: emit unchanged, the row goes on
                if (held_len >= PENDING_DEPTH) release_segment(1'b1, 1'b0);
            end
        end
        if (eol) begin
            if (seg_open) release_segment(1'b1, 1'b0);
            clear_row();
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // valid stays high for a following write, the caller drops it after the last
    task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cur_cfg[idx] = (idx == REG_FREE_RUN_NEEDED || idx == REG_BLACK_NEEDED) ?
                       {5'd0, val[2:0]} : val;
    endtask

    // one pixel word; valid stays high for a following word
    task automatic send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v, bit eol,
                              int typed);
        mark_word_t w;
        if (!calm && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u, y};
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_pixel(y, u, v, eol);
        pixel_count++;
        if (eol) row_count++;
        if (typed >= 0) begin
            w.free_space  = typed[0];
            w.last_result = 1'b1;
            w.row_done    = eol;
            due_marks.push_back(w);
        end else begin
            foreach (step_marks[i]) begin
                w.free_space  = step_marks[i];
                w.last_result = (i == step_marks.size() - 1);
                w.row_done    = eol && (i == step_marks.size() - 1);
                due_marks.push_back(w);
            end
        end
    endtask

    // sender holds off until every expected word is out, then the tail drains
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (due_marks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        mark_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            word_count++;
            if (due_marks.size() == 0) begin
                report($sformatf("unexpected word data=%h user=%b last=%b",
                                 m_tdata, m_tuser, m_tlast));
            end else begin
                w = due_marks.pop_front();
                if (m_tdata !== {7'd0, w.free_space})
                    report($sformatf("free_space exp %0d got data=%h", w.free_space,
                                     m_tdata));
                if (m_tuser[0] !== w.last_result)
                    report($sformatf("last_result exp %0d got %b", w.last_result,
                                     m_tuser));
                if (m_tlast !== w.row_done)
                    report($sformatf("row_done exp %0d got %b", w.row_done, m_tlast));
            end
        end
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end

    // ------------------------------------------------------------------------
    // random pixels
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_comp(logic [7:0] lo, logic [7:0] hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85 && lo <= hi) return 8'($urandom_range(hi, lo));
        if (r < 95) begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return hi;
                2: return lo - 8'd1;
                default: return hi + 8'd1;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void random_range(output logic [7:0] lo, output logic [7:0] hi);
        int a;
        int span;
        a    = $urandom_range(0, 170);
        span = $urandom_range(30, 120);
        lo   = 8'(a);
        hi   = 8'((a + span > 255) ? 255 : a + span);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    pixel_row_t directed [] = '{
        // single-pixel rows: inside, outside, field extremes, range edges
        '{8'd100, 8'd100, 8'd100, 1'b1, 1},
        '{8'd0,   8'd0,   8'd0,   1'b1, 0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 0},
        '{8'd90,  8'd75,  8'd69,  1'b1, 1},
        '{8'd210, 8'd115, 8'd145, 1'b1, 1},
        '{8'd89,  8'd75,  8'd69,  1'b1, 0},
        '{8'd211, 8'd100, 8'd100, 1'b1, 0},
        '{8'd100, 8'd74,  8'd100, 1'b1, 0},
        '{8'd100, 8'd116, 8'd100, 1'b1, 0},
        '{8'd100, 8'd100, 8'd68,  1'b1, 0},
        '{8'd100, 8'd100, 8'd146, 1'b1, 0},
        // segment resolved free by a run of free pixels
        '{8'd0,   8'd0,   8'd0,   1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b1, -1},
        // segment locks the row, later free pixels come out black
        '{8'd0,   8'd0,   8'd0,   1'b0, -1},
        '{8'd255, 8'd255, 8'd255, 1'b0, -1},
        '{8'd0,   8'd255, 8'd0,   1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b1, -1},
        // segment still open at row end keeps its marks
        '{8'd255, 8'd0,   8'd255, 1'b0, -1},
        '{8'd100, 8'd100, 8'd100, 1'b1, -1}
    };

    // threshold pairs per phase: zero, above saturation, max, min, mixed
    int free_thr  [7] = '{0, 7, 4, 1, 1, 6, 2};
    int black_thr [7] = '{0, 7, 4, 1, 4, 2, 5};

    initial begin
        logic [7:0] lo, hi;
        int phase_items;
        int row_len;

        errors = 0;
        pixel_count = 0;
        row_count = 0;
        word_count = 0;
        setting_count = 1;
        calm = 1'b0;
        cur_cfg[REG_LUMA_MIN]        = LUMA_MIN_RST;
        cur_cfg[REG_LUMA_MAX]        = LUMA_MAX_RST;
        cur_cfg[REG_BLUE_MIN]        = BLUE_MIN_RST;
        cur_cfg[REG_BLUE_MAX]        = BLUE_MAX_RST;
        cur_cfg[REG_RED_MIN]         = RED_MIN_RST;
        cur_cfg[REG_RED_MAX]         = RED_MAX_RST;
        cur_cfg[REG_FREE_RUN_NEEDED] = {5'd0, FREE_RUN_RST};
        cur_cfg[REG_BLACK_NEEDED]    = {5'd0, BLACK_RST};
        clear_row();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at reset settings
        foreach (directed[i])
            send_pixel(directed[i].y, directed[i].u, directed[i].v, directed[i].eol,
                       directed[i].typed);
        wait_idle();

        // random rows, one register setting per phase
        for (int ph = 0; ph < 7; ph++) begin
            calm = (ph == 4);
            random_range(lo, hi);
            if (ph == 2) begin
                lo = 8'd0;
                hi = 8'd255;
            end else if (ph == 3) begin
                // empty range, every pixel black
                lo = 8'd255;
                hi = 8'd0;
            end
            write_reg(REG_LUMA_MIN, lo);
            write_reg(REG_LUMA_MAX, hi);
            random_range(lo, hi);
            if (ph == 2) begin
                lo = 8'd0;
                hi = 8'd255;
            end
            write_reg(REG_BLUE_MIN, lo);
            write_reg(REG_BLUE_MAX, hi);
            random_range(lo, hi);
            write_reg(REG_RED_MIN, lo);
            write_reg(REG_RED_MAX, hi);
            // upper data bits of the threshold registers are don't-care
            write_reg(REG_FREE_RUN_NEEDED, {5'($urandom_range(0, 31)), 3'(free_thr[ph])});
            write_reg(REG_BLACK_NEEDED, {5'($urandom_range(0, 31)), 3'(black_thr[ph])});
            cfg_valid <= 1'b0;
            setting_count++;

            phase_items = 0;
            while (phase_items < 8) begin
                row_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24)
                                                      : $urandom_range(1, 10);
                for (int k = 0; k < row_len; k++) begin
                    send_pixel(pick_comp(cur_cfg[REG_LUMA_MIN], cur_cfg[REG_LUMA_MAX]),
                               pick_comp(cur_cfg[REG_BLUE_MIN], cur_cfg[REG_BLUE_MAX]),
                               pick_comp(cur_cfg[REG_RED_MIN], cur_cfg[REG_RED_MAX]),
                               k == row_len - 1, -1);
                    phase_items++;
                end
            end
            wait_idle();
        end

        $display("pixels %0d in %0d rows, %0d result words, %0d register settings",
                 pixel_count, row_count, word_count, setting_count);
        $display("covered range edges, empty and full ranges, zero and saturated thresholds");
        if (errors == 0 && due_marks.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
